// ----- design/fixed_point_reciprocal_newton_core_assert.svh -----
// Assertion macros for the checker of the reciprocal core.
`ifndef FIXED_POINT_RECIPROCAL_NEWTON_CORE_ASSERT_SVH
`define FIXED_POINT_RECIPROCAL_NEWTON_CORE_ASSERT_SVH

// same-cycle implication
`define FPRN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FPRN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/fprn_pkg.sv -----
package fprn_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int DATA_WIDTH = 32;
    localparam int IO_WIDTH   = 32;
    localparam int LIMIT_W    = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(4);

    // full signed product, wide enough for the fraction shift
    localparam int PROD_W = (2 * DATA_WIDTH > FRAC_BITS + DATA_WIDTH) ?
                            2 * DATA_WIDTH : FRAC_BITS + DATA_WIDTH;

    // multiply chain: one multiplier digit per cell
    localparam int MUL_CELLS = 4;
    localparam int DIGIT_W   = (DATA_WIDTH + MUL_CELLS - 1) / MUL_CELLS;
    localparam int MUL_B_W   = DIGIT_W * MUL_CELLS;

    localparam logic [DATA_WIDTH-1:0] FX_ONE = DATA_WIDTH'(64'd1 << FRAC_BITS);
    localparam logic [DATA_WIDTH-1:0] FX_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] FX_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [PROD_W-1:0]  a;
        logic [MUL_B_W-1:0] b;
        logic [PROD_W-1:0]  acc;
    } mul_data_t;

    // 2^(2*FRAC_BITS-1-b) for leading one at b; out of range gives 0
    function automatic logic [DATA_WIDTH-1:0] first_guess(input logic [DATA_WIDTH-1:0] mag);
        logic [DATA_WIDTH-1:0] lead;
        logic [DATA_WIDTH-1:0] guess;
        int k;
        lead  = '0;
        guess = '0;
        for (int i = 0; i < DATA_WIDTH; i++)
        begin
            lead[i] = mag[i] && ((mag >> (i + 1)) == '0);
        end
        for (int j = 0; j < DATA_WIDTH; j++)
        begin
            k = 2 * FRAC_BITS - 1 - j;
            if (k >= 0 && k < DATA_WIDTH)
            begin
                guess[j] = lead[k];
            end
        end
        return guess;
    endfunction

endpackage

// ----- design/fixed_point_reciprocal_newton_core.sv -----
// Fixed-point reciprocal, one item at a time. The divisor is taken while in_stall is low; the
// result goes to an output register, so a finished item can wait there while the next one is
// worked. A zero divisor, or an iteration limit of zero, goes from setup straight to the finish
// state. Otherwise each Newton step runs two dependent multiplies, each through the 4-cell
// multiply chain. An item runs n steps (at most iteration_limit, fewer on early stop).
// iteration_limit is to be written through the cfg port only while the block is idle; the block
// itself does not enforce this. It resets to 4.
module fixed_point_reciprocal_newton_core
    import fprn_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [IO_WIDTH-1:0] divisor,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [IO_WIDTH-1:0] reciprocal,
    output logic                       zero_divisor,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [LIMIT_W-1:0]         cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_MUL1  = 3'd2;
    localparam logic [2:0] S_WAIT1 = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_WAIT2 = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [LIMIT_W-1:0]    limit_reg;
    logic [LIMIT_W-1:0]    iter_reg, iter_next;
    logic [DATA_WIDTH-1:0] mag_reg, mag_next;
    logic                  neg_reg, neg_next;
    logic                  dzero_reg, dzero_next;
    logic [DATA_WIDTH-1:0] x0_reg, x0_next;
    logic [DATA_WIDTH-1:0] y0_reg, y0_next;
    logic [DATA_WIDTH-1:0] res_reg, res_next;
    logic                  res_zero_reg, res_zero_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] out_recip_reg;
    logic                  out_zero_reg;

    logic                  in_xfer;
    logic                  out_load;
    logic [DATA_WIDTH-1:0] d_in;
    logic [DATA_WIDTH-1:0] mul_term;
    logic [DATA_WIDTH-1:0] x1;

    logic                  mul_start;
    logic signed [DATA_WIDTH-1:0] mul_a, mul_b;
    logic                  mul_done;
    logic [PROD_W-1:0]     mul_product;

    fprn_mul_chain u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign d_in      = divisor[DATA_WIDTH-1:0];
    // floor shift of the product, wrapped to the data width
    assign mul_term  = mul_product[FRAC_BITS +: DATA_WIDTH];
    assign x1        = x0_reg + mul_term;

    always_comb
    begin
        state_next    = state_reg;
        iter_next     = iter_reg;
        mag_next      = mag_reg;
        neg_next      = neg_reg;
        dzero_next    = dzero_reg;
        x0_next       = x0_reg;
        y0_next       = y0_reg;
        res_next      = res_reg;
        res_zero_next = res_zero_reg;
        mul_start     = 1'b0;
        mul_a         = signed'(mag_reg);
        mul_b         = signed'(x0_reg);
        out_load      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    neg_next   = d_in[DATA_WIDTH-1];
                    dzero_next = (d_in == '0);
                    if (d_in == FX_MIN)
                    begin
                        mag_next = FX_MAX;
                    end
                    else if (d_in[DATA_WIDTH-1])
                    begin
                        mag_next = -d_in;
                    end
                    else
                    begin
                        mag_next = d_in;
                    end
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                iter_next = '0;
                x0_next   = first_guess(mag_reg);
                if (dzero_reg || limit_reg == '0)
                begin
                    res_next      = '0;
                    res_zero_next = dzero_reg;
                    state_next    = S_FIN;
                end
                else
                begin
                    res_zero_next = 1'b0;
                    state_next    = S_MUL1;
                end
            end
            S_MUL1:
            begin
                mul_start  = 1'b1;
                state_next = S_WAIT1;
            end
            S_WAIT1:
            begin
                if (mul_done)
                begin
                    y0_next    = FX_ONE - mul_term;
                    state_next = S_MUL2;
                end
            end
            S_MUL2:
            begin
                mul_start  = 1'b1;
                mul_a      = signed'(x0_reg);
                mul_b      = signed'(y0_reg);
                state_next = S_WAIT2;
            end
            S_WAIT2:
            begin
                if (mul_done)
                begin
                    iter_next = iter_reg + LIMIT_W'(1);
                    if (y0_reg == '0 || mul_term == '0 || iter_next == limit_reg)
                    begin
                        res_next   = neg_reg ? -x1 : x1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        x0_next    = x1;
                        state_next = S_MUL1;
                    end
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        iter_reg     <= iter_next;
        mag_reg      <= mag_next;
        neg_reg      <= neg_next;
        dzero_reg    <= dzero_next;
        x0_reg       <= x0_next;
        y0_reg       <= y0_next;
        res_reg      <= res_next;
        res_zero_reg <= res_zero_next;
        if (out_load)
        begin
            out_recip_reg <= res_reg;
            out_zero_reg  <= res_zero_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign reciprocal   = IO_WIDTH'(signed'(out_recip_reg));
    assign zero_divisor = out_zero_reg;

endmodule

// ----- design/fprn_mul_cell.sv -----
// One digit of the multiplier: adds a*digit, then passes a up and b down one digit.
module fprn_mul_cell
    import fprn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sign_digit,
    input  logic      in_valid,
    input  mul_data_t in_data,
    output logic      out_valid,
    output mul_data_t out_data
);

    logic                      valid_reg;
    mul_data_t                 data_reg;
    mul_data_t                 data_next;
    logic signed [DIGIT_W:0]   digit;
    logic signed [PROD_W-1:0]  pp;

    always_comb
    begin
        // top cell reads its digit as signed
        digit          = {sign_digit & in_data.b[DIGIT_W-1], in_data.b[DIGIT_W-1:0]};
        pp             = $signed(in_data.a) * digit;
        data_next.a    = in_data.a << DIGIT_W;
        data_next.b    = in_data.b >> DIGIT_W;
        data_next.acc  = in_data.acc + pp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- design/fprn_mul_chain.sv -----
// Signed multiply through a row of MUL_CELLS registered digit cells.
module fprn_mul_chain
    import fprn_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [DATA_WIDTH-1:0] a,
    input  logic signed [DATA_WIDTH-1:0] b,
    output logic                         done,
    output logic [PROD_W-1:0]            product
);

    logic      link_valid [0:MUL_CELLS];
    mul_data_t link_data  [0:MUL_CELLS];

    always_comb
    begin
        link_valid[0]    = start;
        link_data[0].a   = PROD_W'(a);
        link_data[0].b   = MUL_B_W'(b);
        link_data[0].acc = '0;
    end

    for (genvar g = 0; g < MUL_CELLS; g++)
    begin : g_cell
        fprn_mul_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .sign_digit (g == MUL_CELLS - 1),
            .in_valid   (link_valid[g]),
            .in_data    (link_data[g]),
            .out_valid  (link_valid[g+1]),
            .out_data   (link_data[g+1])
        );
    end

    assign done    = link_valid[MUL_CELLS];
    assign product = link_data[MUL_CELLS].acc;

endmodule

// ----- design/fprn_checker.sv -----
`include "fixed_point_reciprocal_newton_core_assert.svh"

module fprn_checker
    import fprn_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_stall,
    input logic signed [IO_WIDTH-1:0] divisor,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic signed [IO_WIDTH-1:0] reciprocal,
    input logic                       zero_divisor
);

    // a zero divisor always comes back as zero
    `FPRN_ASSERT_NOW(a_zero_result, out_valid && zero_divisor, reciprocal == '0,
        "zero_divisor with nonzero reciprocal")

    // one item in flight: the core is busy right after a transfer in
    `FPRN_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
        "input taken while an item is in work")

    // no result can appear the cycle after an item is taken
    `FPRN_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall, !$rose(out_valid),
        "result too soon after transfer in")

    // stalled result holds
    `FPRN_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(reciprocal) && $stable(zero_divisor), "stalled result changed")

endmodule

bind fixed_point_reciprocal_newton_core fprn_checker u_fprn_checker (.*);
